// ===== src/bbff_pkg.sv =====
// Shared constants, token class codes and interface structs for the brace
// block fold finder. No dependencies; every other file but bbff_ram imports it.
`default_nettype none
package bbff_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int LINE_BITS   = 20;
  localparam int ADDR_BITS   = $clog2(STACK_DEPTH);
  localparam int FILL_BITS   = $clog2(STACK_DEPTH + 1);
  localparam int EXCESS_BITS = 16;
  localparam int CLASS_BITS  = 3;
  localparam int DATA_BITS   = ((2 * LINE_BITS + 7) / 8) * 8;

  localparam logic [EXCESS_BITS-1:0] EXCESS_MAX = {EXCESS_BITS{1'b1}};

  typedef enum logic [CLASS_BITS-1:0] {
    CLS_OTHER   = 3'd0,
    CLS_COMMENT = 3'd1,
    CLS_OPEN    = 3'd2,
    CLS_SEMI    = 3'd3,
    CLS_CLOSE   = 3'd4
  } tok_cls_t;

  // Command from the token decoder to the stack.
  typedef struct packed {
    logic                 push;
    logic                 pop;
    logic [LINE_BITS-1:0] line;
  } stk_cmd_t;

  // Stack status seen by the token decoder.
  typedef struct packed {
    logic                 empty;
    logic                 full;
    logic [LINE_BITS-1:0] top;
  } stk_stat_t;

  // One fold range; fold_start sits in the low bits.
  typedef struct packed {
    logic [LINE_BITS-1:0] fold_end;
    logic [LINE_BITS-1:0] fold_start;
  } fold_t;

endpackage
`default_nettype wire

// ===== src/bbff_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none
module bbff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/bbff_stack.sv =====
// Open-line stack: top entry in a register, the rest in a RAM.
// Depends on bbff_pkg and bbff_ram.
`default_nettype none
module bbff_stack (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire bbff_pkg::stk_cmd_t cmd,
  output bbff_pkg::stk_stat_t     stat
);
  import bbff_pkg::*;

  logic [FILL_BITS-1:0] fill;
  logic [FILL_BITS-1:0] fill_next;
  logic [LINE_BITS-1:0] top;
  logic [LINE_BITS-1:0] top_next;
  logic [FILL_BITS-1:0] fill_m1;
  logic [FILL_BITS-1:0] rd_ptr;
  logic [ADDR_BITS-1:0] waddr;
  logic [ADDR_BITS-1:0] raddr;
  logic                 we;
  logic [LINE_BITS-1:0] rdata;
  logic                 fwd_valid;
  logic [LINE_BITS-1:0] fwd_data;
  logic [LINE_BITS-1:0] second;

  // The RAM is always reading the entry just below the top for the coming
  // cycle, so a pop can refill the top register without waiting.
  assign second = fwd_valid ? fwd_data : rdata;

  always_comb begin
    fill_next = fill;
    top_next  = top;
    if (cmd.push) begin
      fill_next = fill + FILL_BITS'(1);
      top_next  = cmd.line;
    end else if (cmd.pop) begin
      fill_next = fill - FILL_BITS'(1);
      top_next  = second;
    end
  end

  assign fill_m1 = fill - FILL_BITS'(1);
  assign rd_ptr  = fill_next - FILL_BITS'(2);
  assign we      = cmd.push && (fill != '0);
  assign waddr   = fill_m1[ADDR_BITS-1:0];
  assign raddr   = rd_ptr[ADDR_BITS-1:0];

  bbff_ram #(
    .WIDTH (LINE_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (top),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      fwd_valid <= 1'b0;
    end else begin
      fill      <= fill_next;
      fwd_valid <= we && (waddr == raddr);
    end
    top      <= top_next;
    fwd_data <= top;
  end

  assign stat.empty = (fill == '0);
  assign stat.full  = (fill == FILL_BITS'(STACK_DEPTH));
  assign stat.top   = top;

endmodule
`default_nettype wire

// ===== src/bbff_outq.sv =====
// Two-entry result queue (output register plus skid register).
// Depends on bbff_pkg.
`default_nettype none
module bbff_outq (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire bbff_pkg::fold_t      fold,
  output logic                      full,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [bbff_pkg::DATA_BITS-1:0] m_tdata
);
  import bbff_pkg::*;

  fold_t head;
  fold_t skid;
  logic  skid_valid;
  logic  pop;

  assign pop = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        head       <= skid;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!m_tvalid || pop) begin
        head     <= fold;
        m_tvalid <= 1'b1;
      end else begin
        skid       <= fold;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      m_tvalid <= 1'b0;
    end
  end

  assign full    = skid_valid;
  assign m_tdata = DATA_BITS'(head);

endmodule
`default_nettype wire

// ===== src/brace_block_fold_finder.sv =====
// Brace block fold finder: top level with the token decoder, anchor and
// excess counter. Depends on bbff_pkg, bbff_stack and bbff_outq.
//
// Usage. Source tokens enter on the s_ channel, one item per token: the
// class travels in s_tuser, the one-based start and end lines in s_tdata.
// Open braces push the line of the statement they belong to (the last
// ordinary token since a comment, semicolon or brace, else the brace line);
// close braces pop it and, when the lines differ, a zero-based fold range
// leaves on the m_ channel. Most tokens produce no result item.
// Throughput is one token per cycle while s_tready is high. A fold range is
// registered in the result queue before it shows on m_tvalid. The top of the
// stack is held in a register and the RAM continuously reads the entry below
// it; a write and a read of the same RAM entry in one cycle are resolved by
// forwarding, so pushes and pops may follow each other in consecutive cycles.
// Results wait in a two-entry queue; while the receiver stalls, tokens are
// still accepted until a second result is queued, then s_tready drops.
// Reset (rst, synchronous, active high) empties the stack, the queue and the
// excess counter and forgets the anchor. The RAM needs no clearing: only
// entries below the fill level are ever used. Opens beyond the stack depth
// are counted (saturating) and their closes give no range.
`default_nettype none
module brace_block_fold_finder (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // s_tdata: start_line, end_line (from bit 0 up), zero padded to bytes
  input  wire logic [bbff_pkg::DATA_BITS-1:0]       s_tdata,
  // s_tuser: token_class
  input  wire logic [bbff_pkg::CLASS_BITS-1:0]      s_tuser,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // m_tdata: fold_start, fold_end (from bit 0 up), zero padded to bytes
  output logic [bbff_pkg::DATA_BITS-1:0]            m_tdata
);
  import bbff_pkg::*;

  logic                   accept;
  logic [LINE_BITS-1:0]   start_line;
  logic [LINE_BITS-1:0]   end_line;
  logic                   anchor_valid;
  logic                   anchor_valid_next;
  logic [LINE_BITS-1:0]   anchor_line;
  logic [LINE_BITS-1:0]   anchor_line_next;
  logic [EXCESS_BITS-1:0] excess;
  logic [EXCESS_BITS-1:0] excess_next;
  stk_cmd_t               cmd;
  stk_stat_t              stat;
  logic                   res_valid;
  fold_t                  fold;
  logic                   q_full;

  assign s_tready   = !q_full;
  assign accept     = s_tvalid && s_tready;
  assign start_line = s_tdata[LINE_BITS-1:0];
  assign end_line   = s_tdata[2*LINE_BITS-1:LINE_BITS];

  // Zero-based conversion wraps a line of zero to all ones.
  assign fold.fold_start = stat.top - LINE_BITS'(1);
  assign fold.fold_end   = end_line - LINE_BITS'(1);

  always_comb begin
    anchor_valid_next = anchor_valid;
    anchor_line_next  = anchor_line;
    excess_next       = excess;
    cmd.push          = 1'b0;
    cmd.pop           = 1'b0;
    cmd.line          = anchor_valid ? anchor_line : start_line;
    res_valid         = 1'b0;
    if (accept) begin
      case (s_tuser)
        CLS_COMMENT, CLS_SEMI: begin
          anchor_valid_next = 1'b0;
        end
        CLS_OPEN: begin
          if (!stat.full) begin
            cmd.push = 1'b1;
          end else if (excess != EXCESS_MAX) begin
            excess_next = excess + EXCESS_BITS'(1);
          end
          anchor_valid_next = 1'b0;
        end
        CLS_CLOSE: begin
          // Closes first cancel opens that overflowed the stack; a close
          // with nothing open leaves everything untouched.
          if (excess != '0) begin
            excess_next       = excess - EXCESS_BITS'(1);
            anchor_valid_next = 1'b0;
          end else if (!stat.empty) begin
            cmd.pop           = 1'b1;
            anchor_valid_next = 1'b0;
            res_valid         = (stat.top != end_line);
          end
        end
        default: begin
          // Ordinary tokens, including undefined class codes.
          anchor_valid_next = 1'b1;
          anchor_line_next  = start_line;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_valid <= 1'b0;
      anchor_line  <= '0;
      excess       <= '0;
    end else begin
      anchor_valid <= anchor_valid_next;
      anchor_line  <= anchor_line_next;
      excess       <= excess_next;
    end
  end

  bbff_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  bbff_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (res_valid),
    .fold     (fold),
    .full     (q_full),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire

// ===== src/bbff_checker.sv =====
// Port-level checks for the brace block fold finder, bound to the top level.
// Depends on bbff_pkg and brace_block_fold_finder.
`default_nettype none
module bbff_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                s_tvalid,
  input wire logic                                s_tready,
  input wire logic [bbff_pkg::CLASS_BITS-1:0]     s_tuser,
  input wire logic                                m_tvalid,
  input wire logic                                m_tready,
  input wire logic [bbff_pkg::DATA_BITS-1:0]      m_tdata
);
  import bbff_pkg::*;

  // A stalled result is held.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // Only a close brace can create a result.
  a_close_only: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser != CLS_CLOSE) && !m_tvalid |=> !m_tvalid)
    else $error("result without a close brace");

  // Input back-pressure only while results are waiting.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result pending");

  // Single-line blocks are never reported.
  a_multi_line: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[LINE_BITS-1:0] != m_tdata[2*LINE_BITS-1:LINE_BITS]))
    else $error("fold range on a single line");

endmodule

bind brace_block_fold_finder bbff_checker u_bbff_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
